### sv/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and constants of the set-associative LRU cache lookup block.
// ----------------------------------------------------------------------------
package salc_pkg;

  localparam int WAYS_DEF  = 8;
  localparam int SETS_DEF  = 256;

  localparam int ADDR_W    = 64;
  localparam int TAG_W     = 64;
  localparam int CNT_W     = 48;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Width of the masked set index before the wrap onto the number of sets.
  localparam int SET_RAW_W = 15;
  // Widest set number the largest set count needs.
  localparam int SET_W_MAX = 12;

  localparam int Q_DEPTH   = 2;

  localparam int BO_W      = 5;
  localparam int SI_W      = 4;
  localparam int WIU_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [BO_W-1:0]  BO_RESET  = 5'd6;
  localparam logic [SI_W-1:0]  SI_RESET  = 4'd8;
  localparam logic [WIU_W-1:0] WIU_RESET = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_OFFSET = 2'd0,
    CFG_SET_INDEX    = 2'd1,
    CFG_WAYS_IN_USE  = 2'd2
  } salc_cfg_idx_t;

  typedef struct packed {
    logic [BO_W-1:0]  block_offset_bits;
    logic [SI_W-1:0]  set_index_bits;
    logic [WIU_W-1:0] ways_in_use;
  } salc_cfg_t;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] address;
  } salc_in_t;

  typedef struct packed {
    logic             hit;
    logic             dirty_evict;
    logic [2:0]       way;
    logic [CNT_W-1:0] access_total;
    logic [CNT_W-1:0] miss_total;
  } salc_out_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic                 func;
    logic [TAG_W-1:0]     tag;
    logic [SET_W_MAX-1:0] set;
  } salc_req_t;

  typedef enum logic [1:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_LOOKUP
  } salc_bstate_t;

endpackage

### sv/set_assoc_lru_cache_lookup.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup
// Set-associative cache lookup with age-based LRU replacement, write-back
// dirty tracking and saturating access and miss counters.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid / in_stall  salc_in_t  (func, address)
//   out      output     out_valid/out_stall  salc_out_t (hit, dirty_evict, way,
//                                            access_total, miss_total)
//   cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// The back end takes one request at a time: it reads a set row from the tag
// and state memories in the idle state and writes it back in the lookup
// state, and the next read waits for that write. After reset the state memory
// is cleared one set per cycle through all SETS sets (256 by default), with
// in_stall held high; configuration writes are taken.
// out_stall holds the result register and backs requests up through the queue.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_lookup #(
  parameter int WAYS = salc_pkg::WAYS_DEF,
  parameter int SETS = salc_pkg::SETS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  salc_pkg::salc_in_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output salc_pkg::salc_out_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [salc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import salc_pkg::*;

  salc_cfg_t cfg_r, cfg_nxt;
  logic      clearing;
  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;
  salc_req_t q_in;
  salc_req_t q_out;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BLOCK_OFFSET: cfg_nxt.block_offset_bits = cfg_data[BO_W-1:0];
        CFG_SET_INDEX:    cfg_nxt.set_index_bits    = cfg_data[SI_W-1:0];
        CFG_WAYS_IN_USE:  cfg_nxt.ways_in_use       = cfg_data[WIU_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_offset_bits <= BO_RESET;
      cfg_r.set_index_bits    <= SI_RESET;
      cfg_r.ways_in_use       <= WIU_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  salc_front #(.SETS(SETS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .clearing (clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  salc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  salc_back #(.WAYS(WAYS), .SETS(SETS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .clearing  (clearing),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### sv/salc_ram.sv
// ----------------------------------------------------------------------------
// salc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/salc_front.sv
// ----------------------------------------------------------------------------
// salc_front
// Accepts requests and splits the address into tag and set number.
// ----------------------------------------------------------------------------
module salc_front #(
  parameter int SETS = salc_pkg::SETS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  salc_pkg::salc_cfg_t cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  salc_pkg::salc_in_t  in_data,
  input  logic                clearing,
  input  logic                q_full,
  output logic                q_push,
  output salc_pkg::salc_req_t q_data
);
  import salc_pkg::*;

  localparam int XW     = SET_RAW_W;
  localparam int PRODW  = 2 * XW + 1;
  localparam int RECIP  = (1 << XW) / SETS;
  localparam int QSW    = 2 * XW;

  logic              s1_v_r, s1_v_nxt;
  logic              s1_func_r;
  logic [TAG_W-1:0]  s1_tag_r;
  logic [XW-1:0]     s1_x_r;
  logic              s2_v_r, s2_v_nxt;
  logic              s2_func_r;
  logic [TAG_W-1:0]  s2_tag_r;
  logic [XW-1:0]     s2_x_r;
  logic [PRODW-1:0]  s2_prod_r;

  logic              adv;
  logic              accept;
  logic [ADDR_W-1:0] addr_sh;
  logic [XW:0]       mask_w;
  logic [XW-1:0]     x_raw;
  logic [5:0]        tag_sh;
  logic [TAG_W-1:0]  tag_raw;
  logic [XW-1:0]     quot;
  logic [QSW-1:0]    qs;
  logic [QSW-1:0]    rem_w;
  logic [XW-1:0]     rem;

  assign adv      = !s2_v_r || !q_full;
  assign in_stall = !adv || clearing;
  assign accept   = in_valid && !in_stall;

  assign addr_sh = in_data.address >> cfg.block_offset_bits;
  assign mask_w  = ((XW+1)'(1) << cfg.set_index_bits) - (XW+1)'(1);
  assign x_raw   = addr_sh[XW-1:0] & mask_w[XW-1:0];
  assign tag_sh  = 6'(cfg.block_offset_bits) + 6'(cfg.set_index_bits);
  assign tag_raw = in_data.address >> tag_sh;

  assign s1_v_nxt = adv ? accept : s1_v_r;
  assign s2_v_nxt = adv ? s1_v_r : s2_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_func_r <= in_data.func;
      s1_tag_r  <= tag_raw;
      s1_x_r    <= x_raw;
      s2_func_r <= s1_func_r;
      s2_tag_r  <= s1_tag_r;
      s2_x_r    <= s1_x_r;
      s2_prod_r <= PRODW'(s1_x_r) * PRODW'(RECIP);
    end
  end

  // The reciprocal quotient is at most one short, so one conditional
  // subtract finishes the wrap onto the number of sets.
  always_comb begin
    quot  = XW'(s2_prod_r >> XW);
    qs    = QSW'(quot) * QSW'(SETS);
    rem_w = QSW'(s2_x_r) - qs;
    rem   = XW'(rem_w);
    if (rem >= XW'(SETS)) begin
      rem = rem - XW'(SETS);
    end
  end

  assign q_push      = s2_v_r && !q_full;
  assign q_data.func = s2_func_r;
  assign q_data.tag  = s2_tag_r;
  assign q_data.set  = rem[SET_W_MAX-1:0];

endmodule

### sv/salc_fifo.sv
// ----------------------------------------------------------------------------
// salc_fifo
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module salc_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  salc_pkg::salc_req_t push_data,
  output logic                full,
  input  logic                pop,
  output salc_pkg::salc_req_t pop_data,
  output logic                empty
);
  import salc_pkg::*;

  localparam int PTRW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW   = $clog2(Q_DEPTH + 1);

  salc_req_t        entry_r [Q_DEPTH];
  logic [PTRW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTRW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full     = (count_r == CW'(Q_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTRW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + PTRW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTRW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + PTRW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### sv/salc_back.sv
// ----------------------------------------------------------------------------
// salc_back
// Reads a set, resolves hit, fill or eviction, updates ages and writes back.
// ----------------------------------------------------------------------------
module salc_back #(
  parameter int WAYS = salc_pkg::WAYS_DEF,
  parameter int SETS = salc_pkg::SETS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  salc_pkg::salc_cfg_t cfg,
  output logic                clearing,
  input  logic                q_empty,
  input  salc_pkg::salc_req_t q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output salc_pkg::salc_out_t out_data
);
  import salc_pkg::*;

  localparam int WW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AW  = $clog2(WAYS + 1);
  localparam int SW  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int XW  = (WW > 3) ? WW : 3;
  localparam int TRW = WAYS * TAG_W;
  localparam int MRW = WAYS * (2 + AW);

  salc_bstate_t     state_r, state_nxt;
  salc_req_t        req_r, req_nxt;
  logic [SW-1:0]    clr_idx_r, clr_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  salc_out_t        out_data_r, out_data_nxt;
  logic [CNT_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0] miss_r, miss_nxt;

  logic             rd_en;
  logic             tag_we;
  logic             meta_we;
  logic [SW-1:0]    meta_waddr;
  logic [MRW-1:0]   meta_wdata;
  logic [TRW-1:0]   tag_rd;
  logic [MRW-1:0]   meta_rd;

  logic [WAYS-1:0][TAG_W-1:0] tag_row, n_tag;
  logic [WAYS-1:0][AW-1:0]    m_age, n_age;
  logic [WAYS-1:0]            m_dirty, n_dirty;
  logic [WAYS-1:0]            m_valid, n_valid;

  logic [AW-1:0]    nways;
  logic [WAYS-1:0]  in_use;
  logic             hit;
  logic [WW-1:0]    hit_way;
  logic             have_free;
  logic [WW-1:0]    free_way;
  logic [WW-1:0]    victim;
  logic [WW-1:0]    way_sel;
  logic             dev;
  logic [AW-1:0]    touched;
  logic [XW-1:0]    way_x;
  logic             out_free;
  logic [CNT_W-1:0] acc_inc;
  logic [CNT_W-1:0] miss_inc;

  salc_ram #(.WIDTH(TRW), .DEPTH(SETS)) u_tag_ram (
    .clk     (clk),
    .wr_en   (tag_we),
    .wr_addr (req_r.set[SW-1:0]),
    .wr_data (n_tag),
    .rd_en   (rd_en),
    .rd_addr (q_data.set[SW-1:0]),
    .rd_data (tag_rd)
  );

  salc_ram #(.WIDTH(MRW), .DEPTH(SETS)) u_meta_ram (
    .clk     (clk),
    .wr_en   (meta_we),
    .wr_addr (meta_waddr),
    .wr_data (meta_wdata),
    .rd_en   (rd_en),
    .rd_addr (q_data.set[SW-1:0]),
    .rd_data (meta_rd)
  );

  assign tag_row = tag_rd;
  assign {m_age, m_dirty, m_valid} = meta_rd;

  // Ways in use: zero counts as one, and the count stops at the way total.
  always_comb begin
    if (cfg.ways_in_use == '0) begin
      nways = AW'(1);
    end else if ({1'b0, cfg.ways_in_use} > (WIU_W+1)'(WAYS)) begin
      nways = AW'(WAYS);
    end else begin
      nways = AW'(cfg.ways_in_use);
    end
    for (int i = 0; i < WAYS; i++) begin
      in_use[i] = (AW'(i) < nways);
    end
  end

  always_comb begin : lookup
    hit       = 1'b0;
    hit_way   = '0;
    have_free = 1'b0;
    free_way  = '0;
    victim    = '0;
    // Lowest matching valid way wins.
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (in_use[i] && m_valid[i] && (tag_row[i] == req_r.tag)) begin
        hit     = 1'b1;
        hit_way = WW'(i);
      end
    end
    // Highest invalid way is the fill target.
    for (int i = 0; i < WAYS; i++) begin
      if (in_use[i] && !m_valid[i]) begin
        have_free = 1'b1;
        free_way  = WW'(i);
      end
    end
    // Oldest way, ties going to the lower index.
    for (int i = 1; i < WAYS; i++) begin
      if (in_use[i] && (m_age[i] > m_age[victim])) begin
        victim = WW'(i);
      end
    end

    if (hit) begin
      way_sel = hit_way;
    end else if (have_free) begin
      way_sel = free_way;
    end else begin
      way_sel = victim;
    end
    dev     = !hit && !have_free && m_dirty[victim];
    touched = m_age[way_sel];

    n_tag   = tag_row;
    n_valid = m_valid;
    n_dirty = m_dirty;
    n_age   = m_age;
    if (hit) begin
      n_dirty[way_sel] = m_dirty[way_sel] | req_r.func;
    end else begin
      n_valid[way_sel] = 1'b1;
      n_dirty[way_sel] = req_r.func;
      n_tag[way_sel]   = req_r.tag;
    end
    for (int i = 0; i < WAYS; i++) begin
      if (in_use[i] && (m_age[i] <= touched) && (m_age[i] < nways)) begin
        n_age[i] = m_age[i] + AW'(1);
      end
    end
    n_age[way_sel] = '0;
  end

  assign way_x    = XW'(way_sel);
  assign out_free = !out_valid_r || !out_stall;
  assign acc_inc  = (acc_r == CNT_MAX) ? acc_r : acc_r + CNT_W'(1);
  assign miss_inc = (miss_r == CNT_MAX) ? miss_r : miss_r + CNT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    clr_idx_nxt   = clr_idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    acc_nxt       = acc_r;
    miss_nxt      = miss_r;
    rd_en         = 1'b0;
    q_pop         = 1'b0;
    tag_we        = 1'b0;
    meta_we       = 1'b0;
    meta_waddr    = req_r.set[SW-1:0];
    meta_wdata    = {n_age, n_dirty, n_valid};
    clearing      = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      BS_CLEAR: begin
        clearing   = 1'b1;
        meta_we    = 1'b1;
        meta_waddr = clr_idx_r;
        meta_wdata = '0;
        if (clr_idx_r == SW'(SETS - 1)) begin
          state_nxt = BS_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + SW'(1);
        end
      end
      BS_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          rd_en     = 1'b1;
          req_nxt   = q_data;
          state_nxt = BS_LOOKUP;
        end
      end
      BS_LOOKUP: begin
        if (out_free) begin
          meta_we  = 1'b1;
          tag_we   = !hit;
          acc_nxt  = acc_inc;
          miss_nxt = hit ? miss_r : miss_inc;
          out_valid_nxt             = 1'b1;
          out_data_nxt.hit          = hit;
          out_data_nxt.dirty_evict  = dev;
          out_data_nxt.way          = way_x[2:0];
          out_data_nxt.access_total = acc_inc;
          out_data_nxt.miss_total   = hit ? miss_r : miss_inc;
          state_nxt = BS_IDLE;
        end
      end
      default: begin
        state_nxt = BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      miss_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      miss_r      <= miss_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sv/salc_checker.sv
// ----------------------------------------------------------------------------
// salc_checker
// Port-level checks of the cache lookup block, bound to the top level.
// ----------------------------------------------------------------------------
module salc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input salc_pkg::salc_out_t             out_data
);
  import salc_pkg::*;

  // A held result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Misses can never outnumber accesses.
  a_miss_le_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.miss_total <= out_data.access_total))
    else $error("miss count above access count");

  // A hit never reports a write-back.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> !out_data.dirty_evict)
    else $error("dirty eviction on a hit");

  // Reset empties the result register and starts the clearing sweep.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_stall)
    else $error("block not idle after reset");

endmodule

bind set_assoc_lru_cache_lookup salc_checker u_salc_checker (.*);

### test/lru_lookup_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_lookup_check
// Watches the request, result and register channels of the cache lookup. It
// keeps its own copy of the tag, valid, dirty and age state, works out the
// result of every accepted request and compares the results field by field.
// ----------------------------------------------------------------------------
module lru_lookup_check #(
  parameter int WAYS = salc_pkg::WAYS_DEF,
  parameter int SETS = salc_pkg::SETS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  salc_pkg::salc_in_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  salc_pkg::salc_out_t             out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              n_checked,
  output int                              n_errors,
  output int                              n_hits,
  output int                              n_wbacks
);

  import salc_pkg::*;

  localparam int MAX_LINES = 30;

  logic [TAG_W-1:0] line_tag   [SETS][WAYS];
  logic             line_valid [SETS][WAYS];
  logic             line_dirty [SETS][WAYS];
  logic [3:0]       line_age   [SETS][WAYS];
  logic [CNT_W-1:0] acc_cnt;
  logic [CNT_W-1:0] miss_cnt;
  int unsigned      offset_bits;
  int unsigned      index_bits;
  int unsigned      ways_cfg;
  salc_out_t        pending_results [$];
  int               checked;
  int               errors;
  int               hits;
  int               wbacks;

  task automatic report(input string msg);
    errors++;
    if (errors <= MAX_LINES) $display("[%0t] lookup mismatch: %s", $time, msg);
  endtask

  task automatic cmp_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want) report($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  // Looks the request up in the model state, updates that state and returns
  // the result the block should produce.
  function automatic salc_out_t cache_access(input salc_in_t req);
    int unsigned      nw;
    int unsigned      set_no;
    int unsigned      way;
    int unsigned      free_way;
    int unsigned      touched;
    logic [63:0]      set_raw;
    logic [TAG_W-1:0] tag;
    logic             hit;
    logic             have_free;
    logic             dev;
    salc_out_t        res;
    nw = (ways_cfg == 0) ? 1 : ((ways_cfg > WAYS) ? WAYS : ways_cfg);
    set_raw = (req.address >> offset_bits) & ((64'd1 << index_bits) - 64'd1);
    set_no = int'(set_raw % SETS);
    tag = req.address >> (offset_bits + index_bits);
    hit = 1'b0;
    have_free = 1'b0;
    dev = 1'b0;
    way = 0;
    free_way = 0;
    for (int i = 0; i < nw; i++) begin
      if (!line_valid[set_no][i]) begin
        have_free = 1'b1;
        free_way = i;
      end else if (line_tag[set_no][i] == tag) begin
        hit = 1'b1;
        way = i;
        line_dirty[set_no][i] = line_dirty[set_no][i] | req.func;
        break;
      end
    end
    if (!hit) begin
      if (have_free) begin
        way = free_way;
        line_valid[set_no][way] = 1'b1;
      end else begin
        // Oldest way wins; ties go to the lowest way number.
        way = 0;
        for (int i = 1; i < nw; i++) begin
          if (line_age[set_no][i] > line_age[set_no][way]) way = i;
        end
        dev = line_dirty[set_no][way];
      end
      line_tag[set_no][way] = tag;
      line_dirty[set_no][way] = req.func;
    end
    touched = line_age[set_no][way];
    for (int i = 0; i < nw; i++) begin
      if (line_age[set_no][i] <= touched && line_age[set_no][i] < nw) begin
        line_age[set_no][i] = line_age[set_no][i] + 4'd1;
      end
    end
    line_age[set_no][way] = '0;
    if (acc_cnt != CNT_MAX) acc_cnt++;
    if (!hit && miss_cnt != CNT_MAX) miss_cnt++;
    if (hit) hits++;
    if (dev) wbacks++;
    res.hit = hit;
    res.dirty_evict = dev;
    res.way = 3'(way);
    res.access_total = acc_cnt;
    res.miss_total = miss_cnt;
    return res;
  endfunction

  always @(posedge clk) begin
    salc_out_t want;
    if (rst_n !== 1'b1) begin
      foreach (line_valid[s, w]) begin
        line_valid[s][w] = 1'b0;
        line_dirty[s][w] = 1'b0;
        line_age[s][w] = '0;
      end
      acc_cnt = '0;
      miss_cnt = '0;
      offset_bits = BO_RESET;
      index_bits = SI_RESET;
      ways_cfg = WIU_RESET;
      pending_results.delete();
    end else begin
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
        case (cfg_index)
          CFG_BLOCK_OFFSET: offset_bits = cfg_data[BO_W-1:0];
          CFG_SET_INDEX:    index_bits = cfg_data[SI_W-1:0];
          CFG_WAYS_IN_USE:  ways_cfg = cfg_data[WIU_W-1:0];
          default: ;
        endcase
      end
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_results.size() == 0) begin
          report($sformatf("result (way %0d) with no request outstanding", out_data.way));
        end else begin
          want = pending_results.pop_front();
          checked++;
          cmp_field("hit", out_data.hit, want.hit);
          cmp_field("dirty_evict", out_data.dirty_evict, want.dirty_evict);
          cmp_field("way", out_data.way, want.way);
          cmp_field("access_total", out_data.access_total, want.access_total);
          cmp_field("miss_total", out_data.miss_total, want.miss_total);
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        pending_results.push_back(cache_access(in_data));
      end
    end
    n_checked <= checked;
    n_errors <= errors;
    n_hits <= hits;
    n_wbacks <= wbacks;
  end

endmodule

### test/tb_set_assoc_lru_cache_lookup.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_cache_lookup
// Drives loads and stores into the cache lookup under a series of register
// settings, with random gaps on the request side and random stalls on the
// result side. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_cache_lookup;

  import salc_pkg::*;

  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_STORE    = 1'b1;
  localparam int   HOLD_CYCLES = 300;
  localparam int   SETTLE      = 8;
  localparam int   PHASE_ITEMS = 230;
  localparam int   CYC_LIMIT   = 400000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  salc_in_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  salc_out_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int n_checked;
  int n_errors;
  int n_hits;
  int n_wbacks;
  int sent;
  int settings;
  int unsigned cur_bo;
  int unsigned cur_si;
  int unsigned cur_wiu;
  bit calm;
  bit hold_req;

  set_assoc_lru_cache_lookup u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lru_lookup_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .n_checked (n_checked),
    .n_errors  (n_errors),
    .n_hits    (n_hits),
    .n_wbacks  (n_wbacks)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cyc;
    cyc = 0;
    while (cyc < CYC_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("set_assoc_lru_cache_lookup test failed");
    $finish;
  end

  // Result side: random stall bursts, stretches without stalls, and one long
  // hold-off on request from the stimulus.
  initial begin : result_side
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  task automatic send_req(input logic op, input logic [ADDR_W-1:0] addr);
    in_data <= '{func: op, address: addr};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Waits until every request has its result, then lets the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (n_checked < sent) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_put(input salc_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  task automatic program_cache(input logic [CFG_DATA_W-1:0] bo,
                               input logic [CFG_DATA_W-1:0] si,
                               input logic [CFG_DATA_W-1:0] wiu);
    cfg_put(CFG_BLOCK_OFFSET, bo);
    cfg_put(CFG_SET_INDEX, si);
    cfg_put(CFG_WAYS_IN_USE, wiu);
    cfg_valid <= 1'b0;
    cur_bo = bo;
    cur_si = si[SI_W-1:0];
    cur_wiu = wiu[WIU_W-1:0];
    settings++;
  endtask

  // Keeps the tag bits of a base address, forces the set field and
  // randomizes the byte offset within the line.
  function automatic logic [ADDR_W-1:0] make_addr(input logic [ADDR_W-1:0] base,
                                                  input int unsigned set_sel);
    logic [ADDR_W-1:0] line_mask;
    logic [ADDR_W-1:0] off_mask;
    line_mask = (64'd1 << (cur_bo + cur_si)) - 64'd1;
    off_mask = (64'd1 << cur_bo) - 64'd1;
    return (base & ~line_mask) | ((64'(set_sel) << cur_bo) & line_mask)
           | ({$urandom, $urandom} & off_mask);
  endfunction

  // Most requests hit a small pool of lines in two sets, slightly larger than
  // the ways in use, so hits, fills and evictions all happen often.
  task automatic traffic(input int count);
    logic [ADDR_W-1:0] pool [12];
    int unsigned       hot_set [2];
    int unsigned       pool_n;
    int unsigned       nw;
    logic [ADDR_W-1:0] addr;
    nw = (cur_wiu == 0) ? 1 : ((cur_wiu > WAYS_DEF) ? WAYS_DEF : cur_wiu);
    pool_n = nw + $urandom_range(1, 4);
    foreach (pool[k]) pool[k] = {$urandom, $urandom};
    foreach (hot_set[k]) hot_set[k] = $urandom_range(0, (1 << cur_si) - 1);
    repeat (count) begin
      if ($urandom_range(0, 19) == 0) pool[$urandom_range(0, pool_n - 1)] = {$urandom, $urandom};
      if ($urandom_range(0, 9) < 8) begin
        addr = make_addr(pool[$urandom_range(0, pool_n - 1)], hot_set[$urandom_range(0, 1)]);
      end else begin
        addr = {$urandom, $urandom};
      end
      send_req($urandom_range(0, 1) ? OP_STORE : OP_LOAD, addr);
    end
  endtask

  initial begin : stimulus
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_BLOCK_OFFSET;
    cfg_data <= '0;
    calm = 1'b0;
    hold_req = 1'b0;
    sent = 0;
    settings = 1;
    cur_bo = BO_RESET;
    cur_si = SI_RESET;
    cur_wiu = WIU_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: 64-byte lines, 256 sets, 8 ways, so the tag starts at
    // bit 14. Fill set 0, hit in it, then force evictions of dirty lines.
    send_req(OP_LOAD, 64'h0);
    send_req(OP_STORE, 64'h3f);
    send_req(OP_LOAD, 64'h20);
    for (int t = 1; t < 8; t++) send_req(OP_STORE, 64'(t) << 14);
    send_req(OP_LOAD, 64'd8 << 14);
    send_req(OP_LOAD, 64'h0);
    send_req(OP_LOAD, '1);
    send_req(OP_STORE, '1);
    send_req(OP_STORE, 64'h8000_0000_0000_0000);
    send_req(OP_LOAD, 64'hffff_ffff_ffff_c03f);
    send_req(OP_STORE, 64'd3 << 14);
    traffic(PHASE_ITEMS + 20);
    drain();

    // A single set with a single way.
    program_cache(0, 0, 1);
    traffic(PHASE_ITEMS);
    drain();

    // The result side holds off long enough for the block to back up.
    program_cache(16, 8, 8);
    hold_req = 1'b1;
    traffic(PHASE_ITEMS);
    drain();

    // Set index wider than the set count, ways in use above the way count.
    program_cache(31, 15, 15);
    traffic(PHASE_ITEMS);
    drain();

    // Zero ways in use behaves as one.
    program_cache(3, 4, 0);
    traffic(PHASE_ITEMS);
    drain();

    program_cache(5, 12, 4);
    traffic(PHASE_ITEMS / 2);
    drain();
    traffic(PHASE_ITEMS / 2);
    drain();

    program_cache(12, 2, 3);
    traffic(PHASE_ITEMS);
    drain();

    calm = 1'b1;
    program_cache(6, 8, 8);
    traffic(PHASE_ITEMS);
    drain();

    $display("Ran %0d loads and stores under %0d register settings,", sent, settings);
    $display("with %0d hits and %0d evictions of dirty lines.", n_hits, n_wbacks);
    if (n_errors == 0) begin
      $display("set_assoc_lru_cache_lookup test passed");
    end else begin
      $display("set_assoc_lru_cache_lookup test failed");
    end
    $finish;
  end

endmodule
